// File: rtl/chacha_pkg.sv
`timescale 1ns / 1ps
package chacha_pkg;

   // configuration port
   localparam int REG_IDX_W = 3;
   localparam int ADDR_W    = REG_IDX_W + 3;
   localparam int DATA_W    = 64;

   localparam logic [REG_IDX_W-1:0] REG_KEY01   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_KEY23   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_KEY45   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_KEY67   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_NONCE01 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_NONCE2  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CTR0    = 3'd6;

   // "expand 32-byte k"
   localparam logic [31:0] SIGMA0 = 32'h6170_7865;
   localparam logic [31:0] SIGMA1 = 32'h3320_646e;
   localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
   localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

   // quarter-round step codes, named after their rotate amount
   localparam logic [1:0] STEP_R16 = 2'd0;
   localparam logic [1:0] STEP_R12 = 2'd1;
   localparam logic [1:0] STEP_R8  = 2'd2;
   localparam logic [1:0] STEP_R7  = 2'd3;

   // operand slots of a quarter-round
   localparam logic [1:0] SEL_A = 2'd0;
   localparam logic [1:0] SEL_B = 2'd1;
   localparam logic [1:0] SEL_C = 2'd2;
   localparam logic [1:0] SEL_D = 2'd3;

   typedef struct packed {
      logic [7:0][31:0] key;
      logic [2:0][31:0] nonce;
      logic [31:0]      ctr0;
   } cfg_type;

   // Word index of operand sel in quarter-round q of a double round.
   // Columns: row sel, column q. Diagonals shift the column by the row.
   function automatic logic [3:0] qr_idx(input logic [2:0] q, input logic [1:0] sel);
      logic [1:0] col;
      if (q[2]) begin
         col = q[1:0] + sel;
      end else begin
         col = q[1:0];
      end
      qr_idx = {sel, col};
   endfunction

   function automatic logic [31:0] init_word(input logic [3:0] idx, input cfg_type cfg,
                                             input logic [31:0] ctr);
      logic [31:0] w;
      case (idx)
         4'd0:    w = SIGMA0;
         4'd1:    w = SIGMA1;
         4'd2:    w = SIGMA2;
         4'd3:    w = SIGMA3;
         4'd4:    w = cfg.key[0];
         4'd5:    w = cfg.key[1];
         4'd6:    w = cfg.key[2];
         4'd7:    w = cfg.key[3];
         4'd8:    w = cfg.key[4];
         4'd9:    w = cfg.key[5];
         4'd10:   w = cfg.key[6];
         4'd11:   w = cfg.key[7];
         4'd12:   w = ctr;
         4'd13:   w = cfg.nonce[0];
         4'd14:   w = cfg.nonce[1];
         4'd15:   w = cfg.nonce[2];
         default: w = '0;
      endcase
      init_word = w;
   endfunction

endpackage

// File: rtl/chacha20_stream_cipher_top.sv
`timescale 1ns / 1ps
// ChaCha20 byte stream cipher. Each request carries one byte, which comes back XORed
// with the next keystream byte; req_msg_start restarts the stream at keystream byte 0
// with the block counter taken from the initial counter register. A byte that needs no
// new block passes from acceptance through the T_DONE state into the output register.
// The first byte of every 64-byte block waits for the block: loading the 16 start
// words, 80 quarter-rounds (read two words a cycle, four add-xor-rotate steps on the
// single shared unit, four single-word write-backs) and the final addition. One
// request is in work at a time; a finished byte may wait in the output register while
// the next request is taken. Key, nonce and initial counter registers are 64-bit
// at byte addresses 8*i; key and nonce are read at the next block, the initial
// counter at the next message start; write them only while no request is in work.
module chacha20_stream_cipher_top import chacha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_msg_start,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_GEN  = 2'd1;
   localparam logic [1:0] T_DONE = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] ctr_ff, ctr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;

   cfg_type     cfg;
   logic [5:0]  eff_pos;
   logic        blk_start, blk_done;
   logic [7:0]  ks_byte;
   logic        out_free;

   chacha_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   chacha_blk u_blk (
      .clock   (clock),
      .reset   (reset),
      .start   (blk_start),
      .cfg     (cfg),
      .ctr     (ctr_ff),
      .rd_pos  (pos_ff),
      .done    (blk_done),
      .ks_byte (ks_byte)
   );

   assign req_stall    = (state_ff != T_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   assign eff_pos   = req_msg_start ? 6'd0 : pos_ff;
   assign blk_start = (state_ff == T_IDLE) && req_valid && (eff_pos == 6'd0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      pos_in       = pos_ff;
      ctr_in       = ctr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               byte_in = req_in_byte;
               pos_in  = eff_pos;
               if (req_msg_start) begin
                  ctr_in = cfg.ctr0;
               end
               state_in = (eff_pos == 6'd0) ? T_GEN : T_DONE;
            end
         end
         T_GEN: begin
            // counter steps once the block has used it
            if (blk_done) begin
               ctr_in   = ctr_ff + 32'd1;
               state_in = T_DONE;
            end
         end
         T_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = byte_ff ^ ks_byte;
               pos_in       = pos_ff + 6'd1;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         pos_ff       <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ctr_ff       <= ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule

// File: rtl/chacha_qr.sv
`timescale 1ns / 1ps
// One add-xor-rotate line of the quarter-round
module chacha_qr import chacha_pkg::*; (
   input  logic [31:0] x,
   input  logic [31:0] y,
   input  logic [31:0] z,
   input  logic [1:0]  step,
   output logic [31:0] sum,
   output logic [31:0] mix
);

   logic [31:0] t;

   assign sum = x + y;
   assign t   = z ^ sum;

   always_comb begin
      case (step)
         STEP_R16: mix = {t[15:0], t[31:16]};
         STEP_R12: mix = {t[19:0], t[31:20]};
         STEP_R8:  mix = {t[23:0], t[31:24]};
         STEP_R7:  mix = {t[24:0], t[31:25]};
         default:  mix = t;
      endcase
   end

endmodule

// File: rtl/chacha_csr.sv
`timescale 1ns / 1ps
module chacha_csr import chacha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type              cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:3];
   assign wr      = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (reg_idx)
            REG_KEY01: begin
               cfg_in.key[0] = pwdata[31:0];
               cfg_in.key[1] = pwdata[63:32];
            end
            REG_KEY23: begin
               cfg_in.key[2] = pwdata[31:0];
               cfg_in.key[3] = pwdata[63:32];
            end
            REG_KEY45: begin
               cfg_in.key[4] = pwdata[31:0];
               cfg_in.key[5] = pwdata[63:32];
            end
            REG_KEY67: begin
               cfg_in.key[6] = pwdata[31:0];
               cfg_in.key[7] = pwdata[63:32];
            end
            REG_NONCE01: begin
               cfg_in.nonce[0] = pwdata[31:0];
               cfg_in.nonce[1] = pwdata[63:32];
            end
            REG_NONCE2: cfg_in.nonce[2] = pwdata[31:0];
            REG_CTR0:   cfg_in.ctr0     = pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY01:   prdata = {cfg_ff.key[1], cfg_ff.key[0]};
         REG_KEY23:   prdata = {cfg_ff.key[3], cfg_ff.key[2]};
         REG_KEY45:   prdata = {cfg_ff.key[5], cfg_ff.key[4]};
         REG_KEY67:   prdata = {cfg_ff.key[7], cfg_ff.key[6]};
         REG_NONCE01: prdata = {cfg_ff.nonce[1], cfg_ff.nonce[0]};
         REG_NONCE2:  prdata = {32'd0, cfg_ff.nonce[2]};
         REG_CTR0:    prdata = {32'd0, cfg_ff.ctr0};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/chacha_blk.sv
`timescale 1ns / 1ps
// Block generator: working words in a 2-read/1-write store, one quarter-round
// at a time through four registers and the shared add-xor-rotate unit.
module chacha_blk import chacha_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  cfg_type     cfg,
   input  logic [31:0] ctr,
   input  logic [5:0]  rd_pos,
   output logic        done,
   output logic [7:0]  ks_byte
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INIT = 4'd1;
   localparam logic [3:0] S_RDAB = 4'd2;
   localparam logic [3:0] S_RDCD = 4'd3;
   localparam logic [3:0] S_LOAD = 4'd4;
   localparam logic [3:0] S_OP   = 4'd5;
   localparam logic [3:0] S_WB   = 4'd6;
   localparam logic [3:0] S_FRD  = 4'd7;
   localparam logic [3:0] S_FADD = 4'd8;

   localparam logic [3:0] LAST_WORD = 4'd15;
   localparam logic [2:0] LAST_QR   = 3'd7;
   localparam logic [3:0] LAST_DR   = 4'd9;
   localparam logic [1:0] LAST_STEP = 2'd3;

   logic [3:0]  state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [2:0]  qr_ff, qr_in;
   logic [3:0]  dr_ff, dr_in;
   logic [1:0]  step_ff, step_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;

   logic [31:0] wmem [16];
   logic [31:0] rdata0_ff, rdata1_ff;
   logic [31:0] ks_ff [16];

   logic [3:0]  ra0, ra1, waddr;
   logic [31:0] wdata;
   logic        we, ks_we;
   logic [31:0] qx, qy, qz, qsum, qmix;
   logic [31:0] ks_word;

   // even steps update a and d, odd steps c and b
   assign qx = step_ff[0] ? c_ff : a_ff;
   assign qy = step_ff[0] ? d_ff : b_ff;
   assign qz = step_ff[0] ? b_ff : d_ff;

   chacha_qr u_qr (
      .x    (qx),
      .y    (qy),
      .z    (qz),
      .step (step_ff),
      .sum  (qsum),
      .mix  (qmix)
   );

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      qr_in    = qr_ff;
      dr_in    = dr_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      ra0      = qr_idx(qr_ff, SEL_A);
      ra1      = qr_idx(qr_ff, SEL_B);
      we       = 1'b0;
      waddr    = idx_ff;
      wdata    = init_word(idx_ff, cfg, ctr);
      ks_we    = 1'b0;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_INIT;
               idx_in   = '0;
            end
         end
         S_INIT: begin
            we     = 1'b1;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == LAST_WORD) begin
               state_in = S_RDAB;
               qr_in    = '0;
               dr_in    = '0;
            end
         end
         S_RDAB: state_in = S_RDCD;
         S_RDCD: begin
            ra0      = qr_idx(qr_ff, SEL_C);
            ra1      = qr_idx(qr_ff, SEL_D);
            a_in     = rdata0_ff;
            b_in     = rdata1_ff;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            c_in     = rdata0_ff;
            d_in     = rdata1_ff;
            step_in  = STEP_R16;
            state_in = S_OP;
         end
         S_OP: begin
            if (step_ff[0]) begin
               c_in = qsum;
               b_in = qmix;
            end else begin
               a_in = qsum;
               d_in = qmix;
            end
            step_in = step_ff + 2'd1;
            if (step_ff == LAST_STEP) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            we    = 1'b1;
            waddr = qr_idx(qr_ff, step_ff);
            case (step_ff)
               SEL_A:   wdata = a_ff;
               SEL_B:   wdata = b_ff;
               SEL_C:   wdata = c_ff;
               SEL_D:   wdata = d_ff;
               default: wdata = a_ff;
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == LAST_STEP) begin
               if (qr_ff == LAST_QR) begin
                  qr_in = '0;
                  if (dr_ff == LAST_DR) begin
                     state_in = S_FRD;
                     idx_in   = '0;
                  end else begin
                     dr_in    = dr_ff + 4'd1;
                     state_in = S_RDAB;
                  end
               end else begin
                  qr_in    = qr_ff + 3'd1;
                  state_in = S_RDAB;
               end
            end
         end
         S_FRD: begin
            ra0      = idx_ff;
            state_in = S_FADD;
         end
         S_FADD: begin
            ks_we  = 1'b1;
            idx_in = idx_ff + 4'd1;
            if (idx_ff == LAST_WORD) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_FRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         qr_ff    <= '0;
         dr_ff    <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         qr_ff    <= qr_in;
         dr_ff    <= dr_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         wmem[waddr] <= wdata;
      end
      rdata0_ff <= wmem[ra0];
      rdata1_ff <= wmem[ra1];
   end

   // feed-forward of the input words
   always_ff @(posedge clock) begin
      if (ks_we) begin
         ks_ff[idx_ff] <= rdata0_ff + init_word(idx_ff, cfg, ctr);
      end
   end

   assign ks_word = ks_ff[rd_pos[5:2]];
   assign ks_byte = ks_word[{rd_pos[1:0], 3'b000} +: 8];

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import chacha_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 1000;   // longer than one block build
   localparam int PHASES        = 8;
   localparam int PHASE_BYTES   = 190;
   localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_kind_type;

   // Tracks the expected cipher bytes from a shadow of the key, nonce and counter.
   class cipher_byte_board;
      logic [63:0] csr_shadow [8];
      logic [31:0] block_ctr;
      logic [31:0] mix [16];
      logic [31:0] ks_words [16];
      logic [5:0]  ks_pos;
      logic [7:0]  expected_out_bytes [$];
      int unsigned errors;

      function new();
         foreach (csr_shadow[i]) csr_shadow[i] = '0;
         foreach (mix[i]) mix[i] = '0;
         foreach (ks_words[i]) ks_words[i] = '0;
         block_ctr = '0;
         ks_pos    = '0;
         errors    = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
         if (idx > REG_CTR0) return;
         if (idx >= REG_NONCE2) value[63:32] = '0;
         csr_shadow[idx] = value;
      endfunction

      function logic [31:0] rotl(logic [31:0] v, int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function void quarter(int a, int b, int c, int d);
         mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
         mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
         mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
         mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
      endfunction

      function void make_keystream_block();
         logic [31:0] start_words [16];
         start_words[0] = SIGMA0;
         start_words[1] = SIGMA1;
         start_words[2] = SIGMA2;
         start_words[3] = SIGMA3;
         for (int i = 0; i < 4; i++) begin
            start_words[4 + 2 * i] = csr_shadow[i][31:0];
            start_words[5 + 2 * i] = csr_shadow[i][63:32];
         end
         start_words[12] = block_ctr;
         start_words[13] = csr_shadow[REG_NONCE01][31:0];
         start_words[14] = csr_shadow[REG_NONCE01][63:32];
         start_words[15] = csr_shadow[REG_NONCE2][31:0];
         mix = start_words;
         for (int r = 0; r < 10; r++) begin
            quarter(0, 4, 8, 12);
            quarter(1, 5, 9, 13);
            quarter(2, 6, 10, 14);
            quarter(3, 7, 11, 15);
            quarter(0, 5, 10, 15);
            quarter(1, 6, 11, 12);
            quarter(2, 7, 8, 13);
            quarter(3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + start_words[i];
         block_ctr = block_ctr + 32'd1;
      endfunction

      function void note_request(logic [7:0] in_byte, logic msg_start);
         logic [31:0] word;
         if (msg_start) begin
            block_ctr = csr_shadow[REG_CTR0][31:0];
            ks_pos    = '0;
         end
         if (ks_pos == 6'd0) make_keystream_block();
         word = ks_words[ks_pos[5:2]] >> (8 * ks_pos[1:0]);
         expected_out_bytes.push_back(in_byte ^ word[7:0]);
         ks_pos = ks_pos + 6'd1;
      endfunction

      function void check_result(logic [7:0] out_byte);
         logic [7:0] want;
         if (expected_out_bytes.size() == 0) begin
            $error("out_byte: no request outstanding, actual %02h", out_byte);
            errors++;
            return;
         end
         want = expected_out_bytes.pop_front();
         if (out_byte !== want) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want, out_byte);
            errors++;
         end
      endfunction

      function void check_register(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
         logic [63:0] want;
         want = csr_shadow[idx];
         if (idx >= REG_NONCE2) value[63:32] = '0;
         if (value !== want) begin
            $error("csr %0d mismatch: expected %016h, actual %016h", idx, want, value);
            errors++;
         end
      endfunction

      function int pending();
         return expected_out_bytes.size();
      endfunction

      function void flag_leftovers();
         if (expected_out_bytes.size() != 0) begin
            $error("out_byte: %0d expected bytes never arrived", expected_out_bytes.size());
            errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [7:0]        req_in_byte;
   logic              req_msg_start;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [7:0]        rsp_out_byte;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   cipher_byte_board cipher_board = new();
   stall_kind_type   stall_mode = STALL_NONE;
   int               stall_run  = 0;
   logic             stall_hold = 1'b0;
   int               gap_max    = 0;
   int               burst_left = 0;
   logic [63:0]      next_csr [8];

   chacha20_stream_cipher_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_msg_start (req_msg_start),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_RANDOM: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         default: begin
            if (stall_run == 0) begin
               stall_hold = ~stall_hold;
               stall_run  = stall_hold ? $urandom_range(1, 20) : $urandom_range(1, 12);
            end else begin
               stall_run--;
            end
            rsp_stall <= stall_hold;
         end
      endcase
   end

   // handshake values are stable by the falling edge
   always @(negedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         cipher_board.check_result(rsp_out_byte);
      end
   end

   task automatic send_byte(input logic [7:0] in_byte, input logic msg_start);
      logic taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gap_max != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_in_byte   <= in_byte;
      req_msg_start <= msg_start;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         if (taken) cipher_board.note_request(in_byte, msg_start);
         @(posedge clock);
      end
      burst_left--;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (cipher_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
      logic done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done = (pready === 1'b1);
         if (done) cipher_board.write_reg(idx, value);
         @(posedge clock);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [REG_IDX_W-1:0] idx);
      logic        done;
      logic [63:0] value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 3'b000};
      @(posedge clock);
      penable <= 1'b1;
      done = 1'b0;
      while (!done) begin
         @(negedge clock);
         done  = (pready === 1'b1);
         value = prdata;
         @(posedge clock);
      end
      cipher_board.check_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Registers only change once the cipher is idle.
   task automatic apply_csrs();
      wait_drained();
      for (int r = REG_KEY01; r <= REG_CTR0; r++) csr_write(r[REG_IDX_W-1:0], next_csr[r]);
      csr_write(REG_UNUSED, {$urandom, $urandom});
      for (int r = REG_KEY01; r <= REG_CTR0; r++) csr_read(r[REG_IDX_W-1:0]);
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == 0);
   endtask

   initial begin
      int phase_bytes;
      int len;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_in_byte   <= '0;
      req_msg_start <= 1'b0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stream with no message start after reset, then restarts mid-block
      stall_mode = STALL_RANDOM;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b1);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);

      // well-known key 00..1f, nonce with 4a in byte 7, counter 1
      next_csr[REG_KEY01]   = 64'h0706_0504_0302_0100;
      next_csr[REG_KEY23]   = 64'h0f0e_0d0c_0b0a_0908;
      next_csr[REG_KEY45]   = 64'h1716_1514_1312_1110;
      next_csr[REG_KEY67]   = 64'h1f1e_1d1c_1b1a_1918;
      next_csr[REG_NONCE01] = 64'h4a00_0000_0000_0000;
      next_csr[REG_NONCE2]  = 64'h0;
      next_csr[REG_CTR0]    = 64'h1;
      apply_csrs();
      send_byte(8'h4c, 1'b1);
      send_byte(8'h61, 1'b0);
      send_byte(8'h64, 1'b0);
      send_byte(8'h69, 1'b0);
      send_byte(8'h65, 1'b0);
      send_byte(8'h73, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h61, 1'b0);

      // every register all ones; the stream carries on without a restart first
      for (int r = REG_KEY01; r <= REG_CTR0; r++) next_csr[r] = '1;
      apply_csrs();
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               for (int r = REG_KEY01; r <= REG_CTR0; r++) next_csr[r] = '1;
            end
            1: begin
               for (int r = REG_KEY01; r <= REG_CTR0; r++) next_csr[r] = '0;
            end
            default: begin
               for (int r = REG_KEY01; r <= REG_CTR0; r++) next_csr[r] = {$urandom, $urandom};
               if (p == 3) next_csr[REG_CTR0] = 64'hFFFF_FFFE;
            end
         endcase
         apply_csrs();
         gap_max    = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 10);
         stall_mode = stall_kind_type'((p + p / 3) % 3);
         phase_bytes = 0;

         // odd phases pick up the old stream, so the new key lands mid-block
         if (p % 2 == 1) begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
            phase_bytes += len;
         end
         // one long message per phase crosses block boundaries (and the counter wrap)
         send_message(130);
         phase_bytes += 130;

         while (phase_bytes < PHASE_BYTES) begin
            if ($urandom_range(0, 7) == 0) begin
               len = $urandom_range(1, 3);
               for (int i = 0; i < len; i++)
                  send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
               len = $urandom_range(1, 130);
               send_message(len);
            end
            phase_bytes += len;
            if ($urandom_range(0, 5) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      cipher_board.flag_leftovers();
      if (cipher_board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
